>>> src/srf_pkg.sv
package srf_pkg;

    // Byte lane width of the text stream and the pattern
    localparam int BYTE_W = 8;

    // Configuration port geometry
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 64;
    localparam int PLEN_W      = 5;

    // Register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LOW    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HIGH   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = 2'd2;

    // Input item kinds
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // Per-cell control: load the incoming byte here, or take the neighbor's byte
    typedef struct packed {
        logic append_here;
        logic shift;
    } cell_ctrl_t;

endpackage

>>> src/substring_removal_filter.sv
// Output: a result beat is registered in the single output register from the input
// beat that causes it. Throughput: one input beat per cycle while each item yields
// at most one result and the output is not stalled; an item with several results
// (end item: n+1, n = bytes held) stalls input; the chain shifts a byte per beat.
// Reset: control state and pattern registers clear (pattern length 1); held cell
// bytes are not cleared, the held count alone marks them empty.
module substring_removal_filter #(
    parameter int MAX_PATTERN = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              kind,
    input  logic [srf_pkg::BYTE_W-1:0]        in_byte,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [srf_pkg::BYTE_W-1:0]        out_byte,
    output logic                              is_end,
    output logic                              run_last,
    input  logic                              cfg_we,
    input  logic [srf_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [srf_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int COUNT_W = $clog2(MAX_PATTERN + 1);
    localparam int BW      = srf_pkg::BYTE_W;

    // Configuration registers
    logic [srf_pkg::CFG_DATA_W-1:0] pattern_low_reg;
    logic [srf_pkg::CFG_DATA_W-1:0] pattern_high_reg;
    logic [srf_pkg::PLEN_W-1:0]     pattern_length_reg;

    // Control state
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               busy_reg, busy_next;
    logic               flush_reg, flush_next;
    logic               out_valid_reg, out_valid_next;
    logic [BW-1:0]      out_byte_reg, out_byte_next;
    logic               is_end_reg, is_end_next;
    logic               run_last_reg, run_last_next;

    // Datapath
    logic [2*srf_pkg::CFG_DATA_W-1:0] pat_all;
    logic [BW-1:0]                    pat_bytes [MAX_PATTERN];
    logic [BW-1:0]                    eval_bytes [MAX_PATTERN];
    logic [MAX_PATTERN-1:0]           match_cur;
    logic [MAX_PATTERN-1:0]           match_prev;
    logic [MAX_PATTERN-1:0]           append_sel;
    logic [srf_pkg::PLEN_W-1:0]       len_wide;
    logic [COUNT_W-1:0]               len;
    logic [COUNT_W-1:0]               m;
    logic [COUNT_W-1:0]               m_dec;
    logic                             accept;
    logic                             append;
    logic                             is_flush;
    logic                             resolving;
    logic                             all0, all1;
    logic                             res0, res1;
    logic                             need_emit;
    logic                             out_free;
    logic                             do_emit;
    logic                             shift;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
            pattern_length_reg <= srf_pkg::PLEN_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                srf_pkg::REG_PATTERN_LOW:    pattern_low_reg    <= cfg_data;
                srf_pkg::REG_PATTERN_HIGH:   pattern_high_reg   <= cfg_data;
                srf_pkg::REG_PATTERN_LENGTH: pattern_length_reg <= cfg_data[srf_pkg::PLEN_W-1:0];
                default:                     ;
            endcase
        end
    end

    // Split the pattern into bytes and clamp its length
    assign pat_all = {pattern_high_reg, pattern_low_reg};

    always_comb
    begin
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            pat_bytes[i] = pat_all[BW*i +: BW];
        end
    end

    always_comb
    begin
        if (pattern_length_reg == '0)
            len_wide = srf_pkg::PLEN_W'(1);
        else if (pattern_length_reg > srf_pkg::PLEN_W'(MAX_PATTERN))
            len_wide = srf_pkg::PLEN_W'(MAX_PATTERN);
        else
            len_wide = pattern_length_reg;
    end

    assign len = len_wide[COUNT_W-1:0];

    // Handshake and item decode
    assign in_stall  = busy_reg | flush_reg;
    assign accept    = in_valid && !in_stall;
    assign append    = accept && (kind == srf_pkg::KIND_DATA);
    assign is_flush  = flush_reg || (accept && (kind == srf_pkg::KIND_END));
    assign resolving = busy_reg || append;

    // Window length under evaluation, and after dropping the front byte
    assign m     = append ? (count_reg + COUNT_W'(1)) : count_reg;
    assign m_dec = m - COUNT_W'(1);

    // Mark the first free cell for the incoming byte
    always_comb
    begin
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            append_sel[i] = append && (COUNT_W'(i) == count_reg);
        end
    end

    // Cell chain
    for (genvar g = 0; g < MAX_PATTERN; g++)
    begin : g_cell
        srf_pkg::cell_ctrl_t     cell_ctrl;
        logic [BW-1:0]           neighbor;
        logic [BW-1:0]           pat_prev;

        assign cell_ctrl.append_here = append_sel[g];
        assign cell_ctrl.shift       = shift;

        if (g == MAX_PATTERN - 1)
        begin : g_tail
            assign neighbor = eval_bytes[g];
        end
        else
        begin : g_body
            assign neighbor = eval_bytes[g+1];
        end

        if (g == 0)
        begin : g_head
            assign pat_prev = pat_bytes[0];
        end
        else
        begin : g_rest
            assign pat_prev = pat_bytes[g-1];
        end

        srf_cell u_cell (
            .clk           (clk),
            .ctrl          (cell_ctrl),
            .in_byte       (in_byte),
            .neighbor_byte (neighbor),
            .pat_cur       (pat_bytes[g]),
            .pat_prev      (pat_prev),
            .eval_byte     (eval_bytes[g]),
            .match_cur     (match_cur[g]),
            .match_prev    (match_prev[g])
        );
    end

    // Prefix checks on the window as is and on the window after a front drop
    always_comb
    begin
        all0 = 1'b1;
        all1 = 1'b1;
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            if (COUNT_W'(i) < m)
                all0 = all0 & match_cur[i];
        end
        for (int i = 1; i < MAX_PATTERN; i++)
        begin
            if (COUNT_W'(i) < m)
                all1 = all1 & match_prev[i];
        end
    end

    assign res0 = (m <= len) && all0;
    assign res1 = (m_dec <= len) && all1;

    assign need_emit = is_flush || (resolving && !res0);
    assign out_free  = !out_valid_reg || !out_stall;
    assign do_emit   = need_emit && out_free;

    // Sequence the flush, the resolve and the output beat
    always_comb
    begin
        count_next     = count_reg;
        busy_next      = busy_reg;
        flush_next     = flush_reg;
        shift          = 1'b0;
        out_valid_next = out_valid_reg && out_stall;
        out_byte_next  = out_byte_reg;
        is_end_next    = is_end_reg;
        run_last_next  = run_last_reg;

        if (is_flush)
        begin
            flush_next = 1'b1;
            busy_next  = 1'b0;
            count_next = m;
            if (do_emit)
            begin
                out_valid_next = 1'b1;
                if (m == '0)
                begin
                    // Nothing left: give the end marker
                    out_byte_next = '0;
                    is_end_next   = 1'b1;
                    run_last_next = 1'b1;
                    flush_next    = 1'b0;
                end
                else
                begin
                    out_byte_next = eval_bytes[0];
                    is_end_next   = 1'b0;
                    run_last_next = 1'b0;
                    shift         = 1'b1;
                    count_next    = m_dec;
                end
            end
        end
        else if (resolving)
        begin
            if (res0)
            begin
                // Hold a prefix, drop a full match
                busy_next  = 1'b0;
                count_next = (m == len) ? '0 : m;
            end
            else if (do_emit)
            begin
                out_valid_next = 1'b1;
                out_byte_next  = eval_bytes[0];
                is_end_next    = 1'b0;
                run_last_next  = res1;
                shift          = 1'b1;
                busy_next      = !res1;
                count_next     = (res1 && (m_dec == len)) ? '0 : m_dec;
            end
            else
            begin
                busy_next  = 1'b1;
                count_next = m;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            busy_reg      <= 1'b0;
            flush_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            busy_reg      <= busy_next;
            flush_reg     <= flush_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        is_end_reg   <= is_end_next;
        run_last_reg <= run_last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign is_end    = is_end_reg;
    assign run_last  = run_last_reg;

`ifndef NO_ASSERTIONS
    // Resolve and flush never run at once
    a_one_mode: assert property (@(posedge clk) disable iff (!rst_n)
        !(busy_reg && flush_reg))
        else $error("resolve and flush active together");

    // Held count stays within the cell chain
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(MAX_PATTERN))
        else $error("held count exceeds chain depth");

    // The end marker always closes its item
    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && is_end_reg) |-> run_last_reg)
        else $error("end marker without run_last");

    // A beat that ends a resolve leaves the block ready for input
    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (do_emit && resolving && res1) |=> !busy_reg)
        else $error("resolve still pending after its last beat");
`endif

endmodule

>>> src/srf_cell.sv
module srf_cell (
    input  logic                         clk,
    input  srf_pkg::cell_ctrl_t          ctrl,
    input  logic [srf_pkg::BYTE_W-1:0]   in_byte,
    input  logic [srf_pkg::BYTE_W-1:0]   neighbor_byte,
    input  logic [srf_pkg::BYTE_W-1:0]   pat_cur,
    input  logic [srf_pkg::BYTE_W-1:0]   pat_prev,
    output logic [srf_pkg::BYTE_W-1:0]   eval_byte,
    output logic                         match_cur,
    output logic                         match_prev
);

    logic [srf_pkg::BYTE_W-1:0] held_reg;
    logic [srf_pkg::BYTE_W-1:0] held_next;

    // Take the incoming byte when this cell is the first free slot
    assign eval_byte = ctrl.append_here ? in_byte : held_reg;

    // Compare against this slot's pattern byte and against the one before it,
    // which is where this byte lands after a shift
    assign match_cur  = (eval_byte == pat_cur);
    assign match_prev = (eval_byte == pat_prev);

    // Advance toward the front on a shift, otherwise keep the evaluated byte
    assign held_next = ctrl.shift ? neighbor_byte : eval_byte;

    always_ff @(posedge clk)
    begin
        held_reg <= held_next;
    end

endmodule
